### design/glhr_pkg.sv
// ----------------------------------------------------------------------------
// Ghost LRU pair hit ratio: shared package
// Types, constants and command codes used by every module of the block but the RAM.
// ----------------------------------------------------------------------------
package glhr_pkg;

    localparam int GHOST_ENTRIES = 64;
    localparam int KEY_BITS      = 64;
    localparam int IDX_W         = $clog2(GHOST_ENTRIES);
    localparam int CNT_W         = $clog2(GHOST_ENTRIES + 1);
    localparam int CAP_W         = 7;
    localparam int HIT_W         = 32;
    localparam int RATIO_W       = 16;
    localparam int KEY_IN_W      = 64;
    localparam int CMD_W         = 2;

    typedef enum logic [CMD_W-1:0] {
        CMD_DEMOTE_PUT = 2'd0,
        CMD_READ_PUT   = 2'd1,
        CMD_PROBE      = 2'd2,
        CMD_CLEAR      = 2'd3
    } t_cmd;

    typedef enum logic {
        REG_DEMOTE_CAP = 1'b0,
        REG_READ_CAP   = 1'b1
    } t_reg_idx;

    // Request from the sequencer to one ghost list.
    typedef struct packed {
        logic                start;
        logic                is_put;
        logic [CNT_W-1:0]    cap;
        logic [KEY_BITS-1:0] key;
    } t_list_req;

    // Status from one ghost list back to the sequencer.
    typedef struct packed {
        logic done;
        logic hit;
    } t_list_rsp;

    // Clamp a capacity register to 1..GHOST_ENTRIES.
    function automatic logic [CNT_W-1:0] eff_cap(input logic [CAP_W-1:0] c);
        logic [CNT_W-1:0] r;
        if (c == '0) begin
            r = CNT_W'(1);
        end else if (32'(c) > GHOST_ENTRIES) begin
            r = CNT_W'(GHOST_ENTRIES);
        end else begin
            r = CNT_W'(c);
        end
        return r;
    endfunction

endpackage

### design/ghost_lru_pair_hit_ratio.sv
// ----------------------------------------------------------------------------
// Ghost LRU pair hit ratio
// Two ghost LRU lists with saturating hit counters and Q0.16 hit ratios.
// ----------------------------------------------------------------------------
// Channel   Dir  Width  Contents
// s_axis    in   72     cmd [1:0], block_key [65:2], zero fill
// m_axis    out  104    hit flags, hit counts, ratios
// cfg       in   1+7    register index, capacity value
//
// A put searches the list and shifts entries to make room or move the key; a probe
// walks both lists and then runs two serial divisions. The list search and the
// divider set the pace.
// Reset is synchronous and empties both lists; counters go to one.
// While a result waits on m_axis the block takes no new item.
// ----------------------------------------------------------------------------
module ghost_lru_pair_hit_ratio (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // [1:0] cmd, [65:2] block_key, [71:66] zero
    input  logic [71:0]  s_axis_tdata,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // [0] demote_hit, [1] read_hit, [33:2] demote_hit_count,
    // [65:34] read_hit_count, [81:66] demote_ratio, [97:82] read_ratio
    output logic [103:0] m_axis_tdata,
    input  logic         i_cfg_valid,
    output logic         o_cfg_ready,
    input  logic         i_cfg_index,
    input  logic [6:0]   i_cfg_data
);
    import glhr_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE, S_DLIST, S_RLIST, S_DDIV, S_RDIV, S_OUT
    } t_state;

    t_state            r_state;
    t_cmd              r_cmd;
    logic [KEY_BITS-1:0] r_key;
    logic [CAP_W-1:0]  r_dcap, r_rcap;
    logic [HIT_W-1:0]  r_dhits, r_rhits;
    logic [RATIO_W-1:0] r_dratio, r_rratio;
    logic              r_dh, r_rh;
    logic              r_go;

    t_list_req dreq, rreq;
    t_list_rsp drsp, rrsp;
    logic      div_start, div_done;
    logic [HIT_W-1:0]  div_num;
    logic [HIT_W:0]    hit_sum;
    logic [RATIO_W-1:0] div_q;

    assign o_cfg_ready   = (r_state == S_IDLE);
    assign s_axis_tready = (r_state == S_IDLE);

    // Configuration writes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dcap <= CAP_W'(64);
            r_rcap <= CAP_W'(64);
        end else if (i_cfg_valid && o_cfg_ready) begin
            if (i_cfg_index == REG_DEMOTE_CAP) r_dcap <= i_cfg_data;
            else                               r_rcap <= i_cfg_data;
        end
    end

    // List requests.
    always_comb begin
        dreq.start  = r_go && (r_state == S_DLIST);
        dreq.is_put = (r_cmd == CMD_DEMOTE_PUT);
        dreq.cap    = eff_cap(r_dcap);
        dreq.key    = r_key;
        rreq.start  = r_go && (r_state == S_RLIST);
        rreq.is_put = (r_cmd == CMD_READ_PUT);
        rreq.cap    = eff_cap(r_rcap);
        rreq.key    = r_key;
    end

    glhr_list u_dlist (.i_clk(i_clk), .i_rst_n(i_rst_n), .i_req(dreq), .o_rsp(drsp));
    glhr_list u_rlist (.i_clk(i_clk), .i_rst_n(i_rst_n), .i_req(rreq), .o_rsp(rrsp));

    assign hit_sum   = {1'b0, r_dhits} + {1'b0, r_rhits};
    assign div_num   = (r_state == S_DDIV) ? r_dhits : r_rhits;
    assign div_start = r_go && (r_state == S_DDIV || r_state == S_RDIV);

    glhr_div u_div (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(div_start),
        .i_num(div_num), .i_den(hit_sum), .o_done(div_done), .o_ratio(div_q)
    );

    // Command sequencer.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_go     <= 1'b0;
            r_dhits  <= HIT_W'(1);
            r_rhits  <= HIT_W'(1);
            r_dratio <= '0;
            r_rratio <= '0;
            r_dh     <= 1'b0;
            r_rh     <= 1'b0;
        end else begin
            r_go <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    if (s_axis_tvalid) begin
                        r_cmd <= t_cmd'(s_axis_tdata[1:0]);
                        r_key <= s_axis_tdata[2 +: KEY_BITS];
                        r_dh  <= 1'b0;
                        r_rh  <= 1'b0;
                        r_go  <= 1'b1;
                        unique case (t_cmd'(s_axis_tdata[1:0]))
                            CMD_DEMOTE_PUT: r_state <= S_DLIST;
                            CMD_READ_PUT:   r_state <= S_RLIST;
                            CMD_PROBE:      r_state <= S_DLIST;
                            CMD_CLEAR: begin
                                r_dhits  <= HIT_W'(1);
                                r_rhits  <= HIT_W'(1);
                                r_dratio <= '0;
                                r_rratio <= '0;
                                r_state  <= S_OUT;
                            end
                            default: r_state <= S_OUT;
                        endcase
                    end
                end
                S_DLIST: begin
                    if (drsp.done) begin
                        if (r_cmd == CMD_PROBE) begin
                            r_dh <= drsp.hit;
                            if (drsp.hit && r_dhits != '1) r_dhits <= r_dhits + HIT_W'(1);
                            r_go    <= 1'b1;
                            r_state <= S_RLIST;
                        end else begin
                            r_state <= S_OUT;
                        end
                    end
                end
                S_RLIST: begin
                    if (rrsp.done) begin
                        if (r_cmd == CMD_PROBE) begin
                            r_rh <= rrsp.hit;
                            if (rrsp.hit && r_rhits != '1) r_rhits <= r_rhits + HIT_W'(1);
                            r_go    <= 1'b1;
                            r_state <= S_DDIV;
                        end else begin
                            r_state <= S_OUT;
                        end
                    end
                end
                S_DDIV: begin
                    if (div_done) begin
                        r_dratio <= div_q;
                        r_go     <= 1'b1;
                        r_state  <= S_RDIV;
                    end
                end
                S_RDIV: begin
                    if (div_done) begin
                        r_rratio <= div_q;
                        r_state  <= S_OUT;
                    end
                end
                S_OUT: begin
                    if (m_axis_tready) r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign m_axis_tvalid = (r_state == S_OUT);
    assign m_axis_tdata  = {6'd0, r_rratio, r_dratio, r_rhits, r_dhits, r_rh, r_dh};

    // Checks.
    a_no_take_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE) |-> !s_axis_tready)
        else $error("input taken while busy");
    a_hits_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_dhits != '0) && (r_rhits != '0))
        else $error("hit counter reached zero");
    a_clear_ratio: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && r_cmd == CMD_CLEAR) |-> (r_dratio == '0 && r_rratio == '0))
        else $error("clear left a ratio");
endmodule

### design/glhr_ram.sv
// ----------------------------------------------------------------------------
// Generic single-port RAM
// One write or read per cycle, read data registered.
// ----------------------------------------------------------------------------
module glhr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    // Registered read; a read at the address being written returns the old data.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        o_rdata <= r_mem[i_addr];
    end
endmodule

### design/glhr_list.sv
// ----------------------------------------------------------------------------
// Ghost LRU list
// Keys held oldest first in a RAM, position 0 being the oldest entry; the
// list is searched and shifted one RAM access a cycle.
// ----------------------------------------------------------------------------
module glhr_list (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  glhr_pkg::t_list_req i_req,
    output glhr_pkg::t_list_rsp o_rsp
);
    import glhr_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE, S_RD, S_CMP, S_SRD, S_SWR, S_EVICT, S_APPEND, S_DONE
    } t_state;

    t_state              r_state;
    logic [CNT_W-1:0]    r_count;
    logic [CNT_W-1:0]    r_pos;
    logic                r_hit;
    logic                r_is_put;
    logic [CNT_W-1:0]    r_cap;
    logic [KEY_BITS-1:0] r_key;

    logic [CNT_W-1:0]    pos_nxt;
    logic                ram_we;
    logic [IDX_W-1:0]    ram_addr;
    logic [KEY_BITS-1:0] ram_wdata;
    logic [KEY_BITS-1:0] ram_rdata;

    assign pos_nxt = r_pos + CNT_W'(1);

    glhr_ram #(.WIDTH(KEY_BITS), .DEPTH(GHOST_ENTRIES)) u_keys (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_addr  (ram_addr),
        .i_wdata (ram_wdata),
        .o_rdata (ram_rdata)
    );

    // RAM access: search reads, shift reads the next entry and writes it one
    // place older, append writes the key at the newest end.
    always_comb begin
        ram_we    = (r_state == S_SWR) || (r_state == S_APPEND);
        ram_wdata = (r_state == S_APPEND) ? r_key : ram_rdata;
        ram_addr  = r_pos[IDX_W-1:0];
        if (r_state == S_SRD) begin
            ram_addr = pos_nxt[IDX_W-1:0];
        end else if (r_state == S_APPEND) begin
            ram_addr = r_count[IDX_W-1:0];
        end
    end

    assign o_rsp.done = (r_state == S_DONE);
    assign o_rsp.hit  = r_hit;

    // Sequencer: an entry is searched in S_RD then S_CMP and shifted in S_SRD then S_SWR.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_pos   <= '0;
            r_hit   <= 1'b0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (i_req.start) begin
                        r_is_put <= i_req.is_put;
                        r_cap    <= i_req.cap;
                        r_key    <= i_req.key;
                        r_hit    <= 1'b0;
                        r_pos    <= '0;
                        r_state  <= S_RD;
                    end
                end
                S_RD: begin
                    if (r_pos >= r_count) begin
                        // Absent key: a put may first need room.
                        if (r_is_put) begin
                            r_state <= S_EVICT;
                        end else begin
                            r_state <= S_DONE;
                        end
                    end else begin
                        r_state <= S_CMP;
                    end
                end
                S_CMP: begin
                    if (ram_rdata == r_key) begin
                        r_hit   <= 1'b1;
                        r_state <= S_SRD;
                    end else begin
                        r_pos   <= pos_nxt;
                        r_state <= S_RD;
                    end
                end
                S_SRD: begin
                    // Remove the entry at r_pos by moving newer ones down.
                    if (pos_nxt < r_count) begin
                        r_state <= S_SWR;
                    end else begin
                        r_count <= r_count - CNT_W'(1);
                        r_state <= r_hit ? S_APPEND : S_EVICT;
                    end
                end
                S_SWR: begin
                    r_pos   <= pos_nxt;
                    r_state <= S_SRD;
                end
                S_EVICT: begin
                    // Drop the oldest entry while the list is at capacity.
                    if (r_count != '0 && r_count >= r_cap) begin
                        r_pos   <= '0;
                        r_state <= S_SRD;
                    end else begin
                        r_state <= S_APPEND;
                    end
                end
                S_APPEND: begin
                    r_count <= r_count + CNT_W'(1);
                    r_state <= S_DONE;
                end
                S_DONE: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end
endmodule

### design/glhr_div.sv
// ----------------------------------------------------------------------------
// Serial ratio divider
// Restoring division of hits * 2^16 by the hit sum, one quotient bit a cycle.
// ----------------------------------------------------------------------------
module glhr_div (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_start,
    input  logic [glhr_pkg::HIT_W-1:0]        i_num,
    input  logic [glhr_pkg::HIT_W:0]          i_den,
    output logic                              o_done,
    output logic [glhr_pkg::RATIO_W-1:0]      o_ratio
);
    import glhr_pkg::*;

    localparam int QW = HIT_W + RATIO_W;

    logic [QW-1:0]    r_quo;
    logic [HIT_W+1:0] r_rem;
    logic [HIT_W:0]   r_den;
    logic [5:0]       r_cnt;
    logic             r_busy;
    logic [HIT_W+1:0] trial;

    assign trial = {r_rem[HIT_W:0], r_quo[QW-1]};

    // One shift-subtract step per cycle over all quotient bits.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            o_done <= 1'b0;
        end else begin
            o_done <= 1'b0;
            if (i_start) begin
                r_quo  <= {i_num, {RATIO_W{1'b0}}};
                r_rem  <= '0;
                r_den  <= i_den;
                r_cnt  <= 6'(QW);
                r_busy <= 1'b1;
            end else if (r_busy) begin
                if (trial >= {1'b0, r_den}) begin
                    r_rem <= trial - {1'b0, r_den};
                    r_quo <= {r_quo[QW-2:0], 1'b1};
                end else begin
                    r_rem <= trial;
                    r_quo <= {r_quo[QW-2:0], 1'b0};
                end
                r_cnt <= r_cnt - 6'd1;
                if (r_cnt == 6'd1) begin
                    r_busy <= 1'b0;
                    o_done <= 1'b1;
                end
            end
        end
    end

    // Saturate to Q0.16; a zero divisor gives zero.
    always_comb begin
        if (r_den == '0) begin
            o_ratio = '0;
        end else if (r_quo[QW-1:RATIO_W] != '0) begin
            o_ratio = '1;
        end else begin
            o_ratio = r_quo[RATIO_W-1:0];
        end
    end
endmodule

### dv/ghost_lru_pair_hit_ratio_tb.sv
// ----------------------------------------------------------------------------
// Ghost LRU pair hit ratio testbench
// Drives puts, probes and clears into the block under several list capacities
// and checks every result item against a behavioural model of both LRU lists,
// the saturating hit counters and the Q0.16 ratios.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

import glhr_pkg::*;

// Result item as it leaves the block.
typedef struct packed {
    logic [15:0] read_ratio;
    logic [15:0] demote_ratio;
    logic [31:0] read_count;
    logic [31:0] demote_count;
    logic        read_hit;
    logic        demote_hit;
} t_ratio_result;

// Behavioural model of both ghost lists, plus a store of pending results.
class ghost_ratio_board;
    // Lists are kept oldest first; only the valid part is modelled.
    logic [63:0]   demote_list[$];
    logic [63:0]   read_list[$];
    logic [6:0]    demote_cap;
    logic [6:0]    read_cap;
    logic [31:0]   demote_hits;
    logic [31:0]   read_hits;
    logic [15:0]   demote_ratio;
    logic [15:0]   read_ratio;
    t_ratio_result pending[$];
    int            mismatches;
    int            checked;
    int            probe_hits;

    function void reset_state();
        demote_list.delete();
        read_list.delete();
        demote_cap   = 7'd64;
        read_cap     = 7'd64;
        demote_hits  = 32'd1;
        read_hits    = 32'd1;
        demote_ratio = '0;
        read_ratio   = '0;
        pending.delete();
    endfunction

    function int clamp_cap(logic [6:0] c);
        int r;
        r = c;
        if (r < 1) r = 1;
        if (r > GHOST_ENTRIES) r = GHOST_ENTRIES;
        return r;
    endfunction

    function void set_cap(t_reg_idx idx, logic [6:0] v);
        if (idx == REG_DEMOTE_CAP) demote_cap = v;
        else read_cap = v;
    endfunction

    function int find_key(ref logic [63:0] lst[$], input logic [63:0] k);
        int r;
        r = -1;
        foreach (lst[p]) if (r < 0 && lst[p] == k) r = p;
        return r;
    endfunction

    function void put_key(ref logic [63:0] lst[$], input int cap, input logic [63:0] k);
        int p;
        p = find_key(lst, k);
        if (p >= 0) begin
            lst.delete(p);
        end else begin
            while (lst.size() > 0 && lst.size() >= cap) lst.delete(0);
        end
        lst.push_back(k);
    endfunction

    function bit probe_key(ref logic [63:0] lst[$], input logic [63:0] k);
        int p;
        p = find_key(lst, k);
        if (p < 0) return 1'b0;
        lst.delete(p);
        lst.push_back(k);
        return 1'b1;
    endfunction

    function logic [15:0] ratio_q16(logic [31:0] num, logic [63:0] sum);
        logic [63:0] q;
        if (sum == 0) return '0;
        q = {num, 16'd0} / sum;
        return (q > 64'd65535) ? 16'hFFFF : q[15:0];
    endfunction

    // Note an accepted input item and queue the result it must cause.
    function void note_item(t_cmd cmd, logic [63:0] k);
        t_ratio_result r;
        logic [63:0]   sum;
        r = '0;
        case (cmd)
            CMD_DEMOTE_PUT: put_key(demote_list, clamp_cap(demote_cap), k);
            CMD_READ_PUT:   put_key(read_list, clamp_cap(read_cap), k);
            CMD_PROBE: begin
                r.demote_hit = probe_key(demote_list, k);
                if (r.demote_hit && demote_hits != 32'hFFFF_FFFF) demote_hits++;
                r.read_hit = probe_key(read_list, k);
                if (r.read_hit && read_hits != 32'hFFFF_FFFF) read_hits++;
                if (r.demote_hit || r.read_hit) probe_hits++;
                sum = 64'(demote_hits) + 64'(read_hits);
                demote_ratio = ratio_q16(demote_hits, sum);
                read_ratio   = ratio_q16(read_hits, sum);
            end
            default: begin
                demote_hits  = 32'd1;
                read_hits    = 32'd1;
                demote_ratio = '0;
                read_ratio   = '0;
            end
        endcase
        r.demote_count = demote_hits;
        r.read_count   = read_hits;
        r.demote_ratio = demote_ratio;
        r.read_ratio   = read_ratio;
        pending.push_back(r);
    endfunction

    // Compare one result item with the oldest expectation.
    function void check_result(logic [103:0] data);
        t_ratio_result got, exp_r;
        got = data[97:0];
        if (pending.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("ERROR: unexpected result item %h", got);
            return;
        end
        exp_r = pending.pop_front();
        checked++;
        if (got.demote_hit !== exp_r.demote_hit || got.read_hit !== exp_r.read_hit ||
            got.demote_count !== exp_r.demote_count ||
            got.read_count !== exp_r.read_count ||
            got.demote_ratio !== exp_r.demote_ratio ||
            got.read_ratio !== exp_r.read_ratio || data[103:98] !== '0) begin
            mismatches++;
            if (mismatches <= 10) begin
                $display("ERROR: result %0d hits d%0b/r%0b exp d%0b/r%0b",
                         checked, got.demote_hit, got.read_hit,
                         exp_r.demote_hit, exp_r.read_hit);
                $display("  counts %0d/%0d exp %0d/%0d, ratios %h/%h exp %h/%h",
                         got.demote_count, got.read_count, exp_r.demote_count,
                         exp_r.read_count, got.demote_ratio, got.read_ratio,
                         exp_r.demote_ratio, exp_r.read_ratio);
            end
        end
    endfunction
endclass

module ghost_lru_pair_hit_ratio_tb;

    localparam int CYCLE_LIMIT = 2_000_000;

    logic         i_clk;
    logic         i_rst_n;
    logic         s_axis_tvalid;
    logic         s_axis_tready;
    logic [71:0]  s_axis_tdata;
    logic         m_axis_tvalid;
    logic         m_axis_tready;
    logic [103:0] m_axis_tdata;
    logic         i_cfg_valid;
    logic         o_cfg_ready;
    logic         i_cfg_index;
    logic [6:0]   i_cfg_data;

    ghost_ratio_board board;
    int           cycles;
    int           hold_cycles;
    bit           stall_on;
    logic [63:0]  key_pool[$];

    ghost_lru_pair_hit_ratio dut (.*);

    // Clock with a 2 ns period.
    always begin
        i_clk = 1'b0;
        #1;
        i_clk = 1'b1;
        #1;
    end

    // Cycle counter and watchdog.
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles", cycles);
            $display("end of test: mismatches");
            $finish;
        end
    end

    // Result side: check accepted items at the rising edge.
    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) board.check_result(m_axis_tdata);
    end

    // Receiver stalls on its own pattern, plus long hold-offs on request.
    always @(negedge i_clk) begin
        if (hold_cycles > 0) begin
            hold_cycles   <= hold_cycles - 1;
            m_axis_tready <= 1'b0;
        end else if (!stall_on) begin
            m_axis_tready <= 1'b1;
        end else begin
            m_axis_tready <= ($urandom_range(0, 9) < 6);
        end
    end

    // Write one capacity register while the block is idle.
    task automatic write_cap(t_reg_idx idx, logic [6:0] v);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= v;
        do @(posedge i_clk); while (!o_cfg_ready);
        board.set_cap(idx, v);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    // Offer one item and wait for its acceptance.
    task automatic send_item(t_cmd cmd, logic [63:0] k);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {6'd0, k, cmd};
        do @(posedge i_clk); while (!s_axis_tready);
        board.note_item(cmd, k);
        @(negedge i_clk);
    endtask

    // Sender idles for a random gap at the end of a random burst.
    task automatic send_paced(t_cmd cmd, logic [63:0] k, inout int burst);
        if (burst <= 0) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(negedge i_clk);
            burst = $urandom_range(1, 20);
        end
        send_item(cmd, k);
        burst--;
    endtask

    task automatic drain();
        s_axis_tvalid <= 1'b0;
        while (board.pending.size() != 0) @(negedge i_clk);
        repeat (20) @(negedge i_clk);
    endtask

    function automatic logic [63:0] rand_key();
        return {$urandom(), $urandom()};
    endfunction

    // Keys drawn mostly from a small pool so that probes hit often.
    function automatic logic [63:0] pool_key();
        if (key_pool.size() == 0 || $urandom_range(0, 9) == 0) begin
            key_pool.push_back(rand_key());
            if (key_pool.size() > 90) key_pool.delete(0);
            return key_pool[key_pool.size() - 1];
        end
        return key_pool[$urandom_range(0, key_pool.size() - 1)];
    endfunction

    task automatic random_phase(int count);
        int   burst;
        int   pick;
        t_cmd cmd;
        burst = 0;
        for (int n = 0; n < count; n++) begin
            pick = $urandom_range(0, 99);
            if (pick < 35) cmd = CMD_DEMOTE_PUT;
            else if (pick < 70) cmd = CMD_READ_PUT;
            else if (pick < 97) cmd = CMD_PROBE;
            else cmd = CMD_CLEAR;
            send_paced(cmd, ($urandom_range(0, 19) == 0) ? rand_key() : pool_key(), burst);
        end
    endtask

    initial begin
        logic [6:0] caps[6];
        int         burst;
        board         = new();
        board.reset_state();
        cycles        = 0;
        hold_cycles   = 0;
        stall_on      = 1'b0;
        i_rst_n       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        m_axis_tready = 1'b1;
        i_cfg_valid   = 1'b0;
        i_cfg_index   = 1'b0;
        i_cfg_data    = '0;
        repeat (4) @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        // Directed: extreme keys, every command, hits in both lists, clear.
        send_item(CMD_PROBE, 64'd0);
        send_item(CMD_DEMOTE_PUT, 64'd0);
        send_item(CMD_READ_PUT, 64'hFFFF_FFFF_FFFF_FFFF);
        send_item(CMD_PROBE, 64'd0);
        send_item(CMD_PROBE, 64'hFFFF_FFFF_FFFF_FFFF);
        send_item(CMD_READ_PUT, 64'd0);
        send_item(CMD_PROBE, 64'd0);
        send_item(CMD_DEMOTE_PUT, 64'hAAAA_AAAA_5555_5555);
        send_item(CMD_DEMOTE_PUT, 64'd0);
        send_item(CMD_PROBE, 64'h5555_5555_AAAA_AAAA);
        send_item(CMD_CLEAR, 64'hFFFF_FFFF_FFFF_FFFF);
        send_item(CMD_PROBE, 64'hAAAA_AAAA_5555_5555);
        drain();

        // Capacity of one, then zero (acts as one) and above the list size.
        write_cap(REG_DEMOTE_CAP, 7'd1);
        write_cap(REG_READ_CAP, 7'd0);
        send_item(CMD_DEMOTE_PUT, 64'd7);
        send_item(CMD_DEMOTE_PUT, 64'd8);
        send_item(CMD_PROBE, 64'd7);
        send_item(CMD_READ_PUT, 64'd9);
        send_item(CMD_READ_PUT, 64'd9);
        send_item(CMD_PROBE, 64'd9);
        drain();
        write_cap(REG_DEMOTE_CAP, 7'd127);
        write_cap(REG_READ_CAP, 7'd64);

        // Random phases over several capacity settings, receiver stalling.
        stall_on = 1'b1;
        caps = '{7'd64, 7'd1, 7'd5, 7'd127, 7'd16, 7'd64};
        foreach (caps[i]) begin
            random_phase(150);
            // Lowering a capacity below the fill takes effect on the next put of a new key.
            drain();
            write_cap(REG_DEMOTE_CAP, caps[i]);
            write_cap(REG_READ_CAP, caps[(i + 3) % 6]);
        end

        // Long receiver hold-off while the sender keeps offering items.
        @(negedge i_clk);
        hold_cycles = 600;
        burst = 100;
        random_phase(40);
        stall_on = 1'b0;
        random_phase(60);
        drain();

        $display("Covered %0d results, %0d probes with a hit, capacities 0..127.",
                 board.checked, board.probe_hits);
        if (board.mismatches == 0) begin
            $display("end of test: clean");
        end else begin
            $display("%0d mismatches", board.mismatches);
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule
